### rtl/core/tksk_pkg.sv
// Shared types, constants and helpers for the top-k score keeper.
// No dependencies; imported by every module of the block.
package tksk_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int LIMIT_W     = 5;
  localparam int IDX_W       = 4;
  localparam int WORD_W      = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] score;
    logic [WORD_W-1:0]        x;
    logic [WORD_W-1:0]        y;
  } entry_t;

  typedef struct packed {
    logic load_new;
    logic load_prev;
  } cell_ctl_t;

  // Clamp a written limit into 1..MAX_ENTRIES.
  function automatic logic [CNT_W-1:0] clamp_limit(logic [LIMIT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > MAX_ENTRIES) begin
      r = CNT_W'(MAX_ENTRIES);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_ones(logic [MAX_ENTRIES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

### rtl/core/tksk_cell.sv
// One list slot of the score keeper: holds an entry, compares it against
// the incoming score and loads either the new entry or its upper neighbor's.
// Depends on tksk_pkg.
module tksk_cell
  import tksk_pkg::*;
(
  input  logic                     clk,
  input  logic                     occupied,
  input  logic signed [WORD_W-1:0] new_score,
  input  entry_t                   new_entry,
  input  entry_t                   prev_entry,
  input  cell_ctl_t                ctl,
  output logic                     keep_above,
  output entry_t                   entry
);

  // Held entry stays ahead of the newcomer on equal or higher score.
  assign keep_above = occupied && (entry.score >= new_score);

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      entry <= new_entry;
    end else if (ctl.load_prev) begin
      entry <= prev_entry;
    end
  end

endmodule

### rtl/core/top_k_score_keeper_top.sv
// Top level of the top-k score keeper: cell chain, control and result register.
// Depends on tksk_pkg and tksk_cell.
//
// Keeps up to list_limit entries (score, x, y) sorted by descending score in
// a chain of MAX_ENTRIES cells, cell 0 holding the best. On every command
// (insert, read, clear) all cells compare their score with the incoming one
// in parallel, and on an insert each cell either holds, loads the new entry,
// or loads its upper neighbor's entry, so the list shifts down by one below
// the insert point in the same cycle. The result is registered and appears
// the cycle after the input transfer; a new input is taken whenever the
// result register is empty or is being drained, so the block sustains one
// command per cycle while out_ready stays high. An insert that would land at
// or beyond the limit is dropped; equal scores go behind existing ones. Write
// list_limit (0 counts as 1, values above MAX_ENTRIES count as MAX_ENTRIES)
// only while the block is idle; the held count is cut down to the new limit
// at once. Cells beyond the held count carry stale data and are never shown.
module top_k_score_keeper_top
  import tksk_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     list_limit_we,
  input  logic [LIMIT_W-1:0]       list_limit,
  // command channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               cmd,
  input  logic signed [WORD_W-1:0] new_score,
  input  logic [WORD_W-1:0]        new_x,
  input  logic [WORD_W-1:0]        new_y,
  input  logic [IDX_W-1:0]         read_index,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     accepted,
  output logic [IDX_W-1:0]         placed_at,
  output logic [CNT_W-1:0]         held_count,
  output logic                     entry_valid,
  output logic signed [WORD_W-1:0] entry_score,
  output logic [WORD_W-1:0]        entry_x,
  output logic [WORD_W-1:0]        entry_y
);

  logic [CNT_W-1:0]       limit;
  logic [CNT_W-1:0]       limit_next;
  logic [CNT_W-1:0]       held;
  logic [CNT_W-1:0]       held_next;
  logic [MAX_ENTRIES-1:0] keep_above;
  logic [MAX_ENTRIES-1:0] occupied;
  cell_ctl_t              ctl [MAX_ENTRIES];
  entry_t                 cells [MAX_ENTRIES];
  entry_t                 new_entry;
  entry_t                 rd_entry;
  logic [CNT_W-1:0]       pos;
  logic                   fire;
  logic                   do_insert;
  logic                   rd_hit;

  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign new_entry = '{score: new_score, x: new_x, y: new_y};

  // Insert point: number of held entries that stay ahead (a prefix).
  assign pos       = count_ones(keep_above);
  assign do_insert = fire && (cmd == CMD_INSERT) && (pos < limit);

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      occupied[i] = 32'(i) < 32'(held);
    end
  end

  // Cell control: hold above the insert point, load new at it, shift below.
  always_comb begin
    ctl[0].load_new  = do_insert && !keep_above[0];
    ctl[0].load_prev = 1'b0;
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      ctl[i].load_new  = do_insert && !keep_above[i] && keep_above[i-1];
      ctl[i].load_prev = do_insert && !keep_above[i] && !keep_above[i-1];
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    tksk_cell u_cell (
      .clk        (clk),
      .occupied   (occupied[g]),
      .new_score  (new_score),
      .new_entry  (new_entry),
      .prev_entry ((g == 0) ? new_entry : cells[(g == 0) ? 0 : g - 1]),
      .ctl        (ctl[g]),
      .keep_above (keep_above[g]),
      .entry      (cells[g])
    );
  end

  // Read port: select the addressed cell.
  assign rd_hit = (32'(read_index) < 32'(held)) && (32'(read_index) < MAX_ENTRIES);

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (32'(i) == 32'(read_index)) begin
        rd_entry = cells[i];
      end
    end
  end

  // Held count after this command; a limit write trims it at once.
  always_comb begin
    limit_next = limit;
    held_next  = held;
    if (fire) begin
      unique case (cmd)
        CMD_INSERT: begin
          if (do_insert && (held < limit)) begin
            held_next = held + CNT_W'(1);
          end
        end
        CMD_CLEAR: held_next = '0;
        default:   held_next = held;
      endcase
    end
    if (list_limit_we) begin
      limit_next = clamp_limit(list_limit);
      if (held > limit_next) begin
        held_next = limit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= clamp_limit(LIMIT_W'(16));
      held  <= '0;
    end else begin
      limit <= limit_next;
      held  <= held_next;
    end
  end

  // Result register: advance on transfer, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted    <= do_insert;
      placed_at   <= do_insert ? IDX_W'(pos) : '0;
      held_count  <= held_next;
      entry_valid <= (cmd == CMD_READ) && rd_hit;
      if ((cmd == CMD_READ) && rd_hit) begin
        entry_score <= rd_entry.score;
        entry_x     <= rd_entry.x;
        entry_y     <= rd_entry.y;
      end else begin
        entry_score <= '0;
        entry_x     <= '0;
        entry_y     <= '0;
      end
    end
  end

endmodule
